// File: sv/quad_order_scale_filter_defines.svh
// Assertion macros for the quad order/scale/filter RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef QUAD_ORDER_SCALE_FILTER_DEFINES_SVH
`define QUAD_ORDER_SCALE_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define QOSF_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("qosf check failed");
`define QOSF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("qosf check failed");
`else
`define QOSF_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define QOSF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: sv/qosf_pkg.sv
// Types, constants and helper functions for the quad order/scale/filter block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package qosf_pkg;

    localparam int unsigned CoordW   = 12;
    localparam int unsigned ScaleW   = 16;
    localparam int unsigned SizeW    = 15;
    localparam int unsigned FixW     = 18;
    localparam int unsigned ProdW    = CoordW + ScaleW;
    localparam int unsigned FixShift = 8;
    localparam int unsigned SqW      = 2 * FixW;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [FixW-1:0]  MaxLimit  = 18'd262128;
    localparam logic [SqW:0]     MinEdgeSq = 37'd4096;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_COL_SCALE  = 2'd0,
        CFG_ROW_SCALE  = 2'd1,
        CFG_IMG_WIDTH  = 2'd2,
        CFG_IMG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } t_point;

    // corners in output order: top-left, top-right, bottom-right, bottom-left
    typedef struct packed {
        t_point tl;
        t_point tr;
        t_point br;
        t_point bl;
    } t_quad_raw;

    typedef struct packed {
        logic [FixW-1:0] x;
        logic [FixW-1:0] y;
    } t_fix_point;

    typedef struct packed {
        t_fix_point tl;
        t_fix_point tr;
        t_fix_point br;
        t_fix_point bl;
    } t_quad_fix;

    // Largest coordinate in 1/16 pixel for an image size, saturated.
    function automatic logic [FixW-1:0] clamp_limit(input logic [SizeW-1:0] size);
        logic [SizeW+3:0] lim;
        lim = {size - SizeW'(1), 4'b0000};
        if (size == '0) begin
            return '0;
        end else if (lim > (SizeW+4)'(MaxLimit)) begin
            return MaxLimit;
        end else begin
            return lim[FixW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: sv/qosf_sort.sv
// Corner ordering: input register, stable sort by x, y order inside each pair, output register.
// Depends on qosf_pkg.
`default_nettype none
module qosf_sort (
    input  wire logic               i_clk,
    input  wire logic               i_adv,
    input  wire qosf_pkg::t_point   i_pt [4],
    output qosf_pkg::t_quad_raw     o_quad
);

    qosf_pkg::t_point    r_pt [4];
    qosf_pkg::t_point    srt [4];
    logic [1:0]          rank [4];
    qosf_pkg::t_quad_raw n_quad;
    qosf_pkg::t_quad_raw r_quad;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pt   <= i_pt;
            r_quad <= n_quad;
        end
    end

    // Rank each corner: ties go to the corner that came first.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rank[i] = 2'd0;
            for (int j = 0; j < 4; j++) begin
                if (j != i) begin
                    if ((r_pt[j].x < r_pt[i].x) || ((r_pt[j].x == r_pt[i].x) && (j < i))) begin
                        rank[i] = rank[i] + 2'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            srt[k] = r_pt[0];
            for (int i = 0; i < 4; i++) begin
                if (rank[i] == 2'(k)) begin
                    srt[k] = r_pt[i];
                end
            end
        end
    end

    // Upper corner of each pair takes the first one on equal y.
    always_comb begin
        if (srt[0].y > srt[1].y) begin
            n_quad.tl = srt[1];
            n_quad.bl = srt[0];
        end else begin
            n_quad.tl = srt[0];
            n_quad.bl = srt[1];
        end
        if (srt[2].y > srt[3].y) begin
            n_quad.tr = srt[3];
            n_quad.br = srt[2];
        end else begin
            n_quad.tr = srt[2];
            n_quad.br = srt[3];
        end
    end

    assign o_quad = r_quad;

endmodule
`default_nettype wire

// File: sv/qosf_lane.sv
// One coordinate lane: Q4.12 scale, truncate to 1/16 pixel, clamp to the image.
// Depends on qosf_pkg.
`default_nettype none
module qosf_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_adv,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_coord,
    input  wire logic [qosf_pkg::ScaleW-1:0]   i_scale,
    input  wire logic [qosf_pkg::FixW-1:0]     i_limit,
    output logic      [qosf_pkg::FixW-1:0]     o_value
);

    localparam int unsigned ShW = qosf_pkg::ProdW - qosf_pkg::FixShift;

    logic [qosf_pkg::ProdW-1:0] n_prod;
    logic [qosf_pkg::ProdW-1:0] r_prod;
    logic [ShW-1:0]             shifted;
    logic [qosf_pkg::FixW-1:0]  n_value;
    logic [qosf_pkg::FixW-1:0]  r_value;

    assign n_prod  = qosf_pkg::ProdW'(i_coord) * qosf_pkg::ProdW'(i_scale);
    assign shifted = r_prod[qosf_pkg::ProdW-1:qosf_pkg::FixShift];
    assign n_value = (shifted > ShW'(i_limit)) ? i_limit : shifted[qosf_pkg::FixW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod  <= n_prod;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

// File: sv/qosf_edge.sv
// Merge stage: squared edge lengths from the top-left corner, keep/drop, output register.
// Depends on qosf_pkg and quad_order_scale_filter_defines.svh.
`default_nettype none
`include "quad_order_scale_filter_defines.svh"
module qosf_edge (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_valid,
    input  wire qosf_pkg::t_quad_fix i_quad,
    output logic                     o_valid,
    output qosf_pkg::t_quad_fix      o_quad
);

    localparam int unsigned FixW = qosf_pkg::FixW;
    localparam int unsigned SqW  = qosf_pkg::SqW;

    logic [FixW-1:0]     dx_top, dy_top, dx_left, dy_left;
    logic [SqW-1:0]      r_sq [4];
    logic [SqW-1:0]      n_sq [4];
    logic                r_sq_valid;
    qosf_pkg::t_quad_fix r_sq_quad;
    logic [SqW:0]        len_top, len_left;
    logic                keep;
    logic                r_out_valid;
    qosf_pkg::t_quad_fix r_out_quad;

    function automatic logic [FixW-1:0] abs_diff(input logic [FixW-1:0] a,
                                                 input logic [FixW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign dx_top  = abs_diff(i_quad.tl.x, i_quad.tr.x);
    assign dy_top  = abs_diff(i_quad.tl.y, i_quad.tr.y);
    assign dx_left = abs_diff(i_quad.tl.x, i_quad.bl.x);
    assign dy_left = abs_diff(i_quad.tl.y, i_quad.bl.y);

    assign n_sq[0] = SqW'(dx_top) * SqW'(dx_top);
    assign n_sq[1] = SqW'(dy_top) * SqW'(dy_top);
    assign n_sq[2] = SqW'(dx_left) * SqW'(dx_left);
    assign n_sq[3] = SqW'(dy_left) * SqW'(dy_left);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sq      <= n_sq;
            r_sq_quad <= i_quad;
        end
    end

    assign len_top  = (SqW+1)'(r_sq[0]) + (SqW+1)'(r_sq[1]);
    assign len_left = (SqW+1)'(r_sq[2]) + (SqW+1)'(r_sq[3]);
    assign keep     = (len_top > qosf_pkg::MinEdgeSq) && (len_left > qosf_pkg::MinEdgeSq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_sq_valid  <= i_valid;
            // drop quads with a short edge
            r_out_valid <= r_sq_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_quad <= r_sq_quad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_quad  = r_out_quad;

    `QOSF_ASSERT_IMPLY(a_out_not_degenerate, i_clk, i_rst_n, r_out_valid,
        (r_out_quad.tl.x != r_out_quad.tr.x) || (r_out_quad.tl.y != r_out_quad.tr.y))
    `QOSF_ASSERT_NEXT(a_sq_hold, i_clk, i_rst_n, r_sq_valid && !i_adv, r_sq_valid)
    `QOSF_ASSERT_NEXT(a_out_from_sq, i_clk, i_rst_n, i_adv && !r_sq_valid, !r_out_valid)

endmodule
`default_nettype wire

// File: sv/quad_order_scale_filter.sv
// Top level of the quad order/scale/filter block: config registers, valid pipeline, lanes.
// Depends on qosf_pkg, qosf_sort, qosf_lane, qosf_edge.
`default_nettype none
// Takes one quad a cycle while o_in_ready is high and gives at most one
// result per quad through its stages (input register, corner sort, scale
// multiply, clamp, edge squares, output register). The whole pipeline moves
// as one while the output register is empty or being taken, so o_in_ready
// drops only while a result waits. Eight coordinate lanes scale in parallel;
// quads with an edge of 4 pixels or less leaving the top-left corner produce
// no result. Write configuration only while no quad is in flight; the clamp
// limits are registered from the stored image sizes.
module quad_order_scale_filter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner1_x,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner1_y,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner2_x,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner2_y,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner3_x,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner3_y,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner4_x,
    input  wire logic [qosf_pkg::CoordW-1:0]   i_corner4_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [qosf_pkg::FixW-1:0]     o_top_left_x,
    output logic      [qosf_pkg::FixW-1:0]     o_top_left_y,
    output logic      [qosf_pkg::FixW-1:0]     o_top_right_x,
    output logic      [qosf_pkg::FixW-1:0]     o_top_right_y,
    output logic      [qosf_pkg::FixW-1:0]     o_bottom_right_x,
    output logic      [qosf_pkg::FixW-1:0]     o_bottom_right_y,
    output logic      [qosf_pkg::FixW-1:0]     o_bottom_left_x,
    output logic      [qosf_pkg::FixW-1:0]     o_bottom_left_y,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [qosf_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [qosf_pkg::CfgDataW-1:0] i_cfg_data
);

    logic [qosf_pkg::ScaleW-1:0] r_col_scale, r_row_scale;
    logic [qosf_pkg::SizeW-1:0]  r_img_width, r_img_height;
    logic [qosf_pkg::FixW-1:0]   r_lim_x, r_lim_y;
    logic [3:0]                  r_vld;
    logic                        adv;
    logic                        out_valid;
    qosf_pkg::t_point            in_pt [4];
    qosf_pkg::t_quad_raw         sorted;
    qosf_pkg::t_quad_fix         scaled;
    qosf_pkg::t_quad_fix         out_quad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_scale  <= 16'd4096;
            r_row_scale  <= 16'd4096;
            r_img_width  <= 15'd16384;
            r_img_height <= 15'd16384;
        end else if (i_cfg_valid) begin
            unique case (qosf_pkg::t_cfg_idx'(i_cfg_index))
                qosf_pkg::CFG_COL_SCALE:  r_col_scale  <= i_cfg_data;
                qosf_pkg::CFG_ROW_SCALE:  r_row_scale  <= i_cfg_data;
                qosf_pkg::CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data[qosf_pkg::SizeW-1:0];
                qosf_pkg::CFG_IMG_HEIGHT: r_img_height <= i_cfg_data[qosf_pkg::SizeW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_x <= qosf_pkg::clamp_limit(r_img_width);
        r_lim_y <= qosf_pkg::clamp_limit(r_img_height);
    end

    // Advance every stage together unless a result waits at the output.
    assign adv        = !out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[2:0], i_in_valid};
        end
    end

    assign in_pt[0] = '{x: i_corner1_x, y: i_corner1_y};
    assign in_pt[1] = '{x: i_corner2_x, y: i_corner2_y};
    assign in_pt[2] = '{x: i_corner3_x, y: i_corner3_y};
    assign in_pt[3] = '{x: i_corner4_x, y: i_corner4_y};

    qosf_sort u_sort (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_pt   (in_pt),
        .o_quad (sorted)
    );

    qosf_lane u_lane_tl_x (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.tl.x),
        .i_scale(r_col_scale), .i_limit(r_lim_x), .o_value(scaled.tl.x));
    qosf_lane u_lane_tl_y (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.tl.y),
        .i_scale(r_row_scale), .i_limit(r_lim_y), .o_value(scaled.tl.y));
    qosf_lane u_lane_tr_x (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.tr.x),
        .i_scale(r_col_scale), .i_limit(r_lim_x), .o_value(scaled.tr.x));
    qosf_lane u_lane_tr_y (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.tr.y),
        .i_scale(r_row_scale), .i_limit(r_lim_y), .o_value(scaled.tr.y));
    qosf_lane u_lane_br_x (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.br.x),
        .i_scale(r_col_scale), .i_limit(r_lim_x), .o_value(scaled.br.x));
    qosf_lane u_lane_br_y (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.br.y),
        .i_scale(r_row_scale), .i_limit(r_lim_y), .o_value(scaled.br.y));
    qosf_lane u_lane_bl_x (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.bl.x),
        .i_scale(r_col_scale), .i_limit(r_lim_x), .o_value(scaled.bl.x));
    qosf_lane u_lane_bl_y (.i_clk(i_clk), .i_adv(adv), .i_coord(sorted.bl.y),
        .i_scale(r_row_scale), .i_limit(r_lim_y), .o_value(scaled.bl.y));

    qosf_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_vld[3]),
        .i_quad  (scaled),
        .o_valid (out_valid),
        .o_quad  (out_quad)
    );

    assign o_out_valid      = out_valid;
    assign o_top_left_x     = out_quad.tl.x;
    assign o_top_left_y     = out_quad.tl.y;
    assign o_top_right_x    = out_quad.tr.x;
    assign o_top_right_y    = out_quad.tr.y;
    assign o_bottom_right_x = out_quad.br.x;
    assign o_bottom_right_y = out_quad.br.y;
    assign o_bottom_left_x  = out_quad.bl.x;
    assign o_bottom_left_y  = out_quad.bl.y;

endmodule
`default_nettype wire
